FILE: rtl/core/bellman_ford_shortest_path_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATH_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATH_MACROS_SVH

// same-cycle implication
`define BFSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfsp check failed");

// next-cycle implication
`define BFSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfsp check failed");

`endif

FILE: rtl/core/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Types, constants and controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W    = 6;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 22;
  localparam int NCNT_W    = 7;
  localparam int OP_W      = 2;
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
  localparam int LEN_W     = NODE_W + 1;

  localparam logic [DIST_W-1:0] DIST_CAP = {DIST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SOLVE  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_EFETCH,
    S_EREAD,
    S_RELAX,
    S_CHECK,
    S_WALK_RD,
    S_WALK_WR,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0]   from;
    logic [NODE_W-1:0]   to;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] total;
  } stack_t;

  typedef struct packed {
    logic clear_store;
    logic append;
    logic capture;
    logic load_trivial;
    logic init;
    logic edge_rd;
    logic dist_rd;
    logic relax;
    logic load_unreach;
    logic walk_start;
    logic walk_rd;
    logic walk_wr;
    logic emit_rd;
    logic emit_ld;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic no_work;
    logic last_edge;
    logic last_pass;
    logic dst_reached;
    logic walk_done;
    logic out_last;
  } status_t;

endpackage

FILE: rtl/core/bellman_ford_shortest_path.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// Single-source shortest path over a stored edge list, one path per solve.
// ----------------------------------------------------------------------------
// Clear and append requests are taken while idle, so edges load back to
// back. A solve holds off the input until its last result is taken; it
// runs P = min(node_count-1, 63) passes over the E stored edges, each edge
// relaxation an edge-store read, a distance-table read and a compare/write
// run in turn by the controller, then walks and emits the path. Start equal
// to destination answers in the next cycle, an unreachable destination
// right after the passes. Results leave through a registered output stage;
// the user must write node_count via cfg_* while idle; the block does not check.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path import bfsp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NCNT_W-1:0]   cfg_node_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [NODE_W-1:0]   in_edge_from,
  input  logic [NODE_W-1:0]   in_edge_to,
  input  logic [WEIGHT_W-1:0] in_edge_weight,
  input  logic [NODE_W-1:0]   in_start_node,
  input  logic [NODE_W-1:0]   in_dest_node,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NODE_W-1:0]   out_path_node,
  output logic [DIST_W-1:0]   out_path_distance,
  output logic                out_reachable,
  output logic                out_last
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bfsp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_node_count    (cfg_node_count),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_edge_weight    (in_edge_weight),
    .in_start_node     (in_start_node),
    .in_dest_node      (in_dest_node),
    .cmd               (cmd),
    .st                (st),
    .out_path_node     (out_path_node),
    .out_path_distance (out_path_distance),
    .out_reachable     (out_reachable),
    .out_last          (out_last)
  );

endmodule

FILE: rtl/core/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer: request decode, relaxation passes, path walk and result emit.
// ----------------------------------------------------------------------------
`include "bellman_ford_shortest_path_macros.svh"

module bfsp_ctrl import bfsp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_opcode,
  output logic            out_valid,
  input  logic            out_ready,
  input  status_t         st,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT_WAIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_CLEAR) begin
            cmd.clear_store = 1'b1;
          end else if (in_opcode == OP_APPEND) begin
            cmd.append = 1'b1;
          end else if (in_opcode == OP_SOLVE) begin
            cmd.capture = 1'b1;
            if (st.trivial) begin
              cmd.load_trivial = 1'b1;
              state_nxt        = S_EMIT_WAIT;
            end else begin
              state_nxt = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = st.no_work ? S_CHECK : S_EFETCH;
      end
      S_EFETCH: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_EREAD;
      end
      S_EREAD: begin
        cmd.dist_rd = 1'b1;
        state_nxt   = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax = 1'b1;
        state_nxt = (st.last_edge && st.last_pass) ? S_CHECK : S_EFETCH;
      end
      S_CHECK: begin
        if (st.dst_reached) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK_RD;
        end else begin
          cmd.load_unreach = 1'b1;
          state_nxt        = S_EMIT_WAIT;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = st.walk_done ? S_EMIT_RD : S_WALK_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          if (st.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `BFSP_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
  `BFSP_ASSERT_NEXT(a_final_frees, out_valid && out_ready && st.out_last, in_ready)
  `BFSP_ASSERT_NOW(a_result_loaded, $rose(out_valid),
                   $past(cmd.emit_ld || cmd.load_trivial || cmd.load_unreach))
  `BFSP_ASSERT_NEXT(a_relax_follows_read, cmd.dist_rd, cmd.relax)

endmodule

FILE: rtl/core/bfsp_dp.sv
// ----------------------------------------------------------------------------
// bfsp_dp
// Datapath: edge store, distance/predecessor tables, path stack, counters.
// ----------------------------------------------------------------------------
module bfsp_dp import bfsp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [NCNT_W-1:0]   cfg_node_count,
  input  logic [NODE_W-1:0]   in_edge_from,
  input  logic [NODE_W-1:0]   in_edge_to,
  input  logic [WEIGHT_W-1:0] in_edge_weight,
  input  logic [NODE_W-1:0]   in_start_node,
  input  logic [NODE_W-1:0]   in_dest_node,
  input  cmd_t                cmd,
  output status_t             st,
  output logic [NODE_W-1:0]   out_path_node,
  output logic [DIST_W-1:0]   out_path_distance,
  output logic                out_reachable,
  output logic                out_last
);

  logic [NCNT_W-1:0]    node_count_r;
  logic [ECNT_W-1:0]    edge_total_r;
  logic [EDGE_AW-1:0]   e_idx_r;
  logic [NODE_W-1:0]    pass_r;
  logic [NODE_W-1:0]    src_r, dst_r, cur_r, idx_r;
  logic [LEN_W-1:0]     len_r;
  logic [MAX_NODES-1:0] reached_r;

  logic [NODE_W-1:0]    out_node_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic                 out_reach_r, out_last_r;

  edge_t                edge_q;
  logic [DIST_W-1:0]    dist_a_q, dist_b_q;
  logic [NODE_W-1:0]    pred_q;
  stack_t               stack_q, stack_wd;

  logic [NCNT_W-1:0]    pass_limit;
  logic [DIST_W:0]      sum;
  logic [DIST_W-1:0]    cand;
  logic                 better;
  logic                 dist_we;
  logic [NODE_W-1:0]    dist_waddr;
  logic [DIST_W-1:0]    dist_wdata;
  logic [NODE_W-1:0]    dist_a_raddr;

  // ---- edge store ----
  bfsp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.append && (edge_total_r != ECNT_W'(MAX_EDGES))),
    .waddr (edge_total_r[EDGE_AW-1:0]),
    .wdata ({in_edge_from, in_edge_to, in_edge_weight}),
    .re    (cmd.edge_rd),
    .raddr (e_idx_r),
    .rdata (edge_q)
  );

  // ---- distance table, two copies for the from/to reads ----
  assign dist_a_raddr = cmd.walk_rd ? cur_r : edge_q.from;

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_a_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .re    (cmd.dist_rd || cmd.walk_rd),
    .raddr (dist_a_raddr),
    .rdata (dist_a_q)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_b_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .re    (cmd.dist_rd),
    .raddr (edge_q.to),
    .rdata (dist_b_q)
  );

  bfsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pred_ram (
    .clk   (clk),
    .we    (cmd.relax && better),
    .waddr (edge_q.to),
    .wdata (edge_q.from),
    .re    (cmd.walk_rd),
    .raddr (cur_r),
    .rdata (pred_q)
  );

  assign stack_wd = '{node: cur_r, total: dist_a_q};

  bfsp_ram #(.WIDTH($bits(stack_t)), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.walk_wr),
    .waddr (len_r[NODE_W-1:0]),
    .wdata (stack_wd),
    .re    (cmd.emit_rd),
    .raddr (idx_r),
    .rdata (stack_q)
  );

  // ---- relaxation ----
  always_comb begin
    sum    = {1'b0, dist_a_q} + (DIST_W+1)'(edge_q.weight);
    cand   = sum[DIST_W] ? DIST_CAP : sum[DIST_W-1:0];
    // unreached target reads as infinity, above any capped candidate
    better = reached_r[edge_q.from] &&
             (!reached_r[edge_q.to] || (cand < dist_b_q));
    dist_we    = cmd.init || (cmd.relax && better);
    dist_waddr = cmd.init ? src_r : edge_q.to;
    dist_wdata = cmd.init ? '0 : cand;
  end

  always_comb begin
    if (node_count_r == '0) begin
      pass_limit = '0;
    end else if (node_count_r > NCNT_W'(MAX_NODES)) begin
      pass_limit = NCNT_W'(MAX_NODES - 1);
    end else begin
      pass_limit = node_count_r - 1'b1;
    end
  end

  assign st.trivial     = (in_start_node == in_dest_node);
  assign st.no_work     = (pass_limit == '0) || (edge_total_r == '0);
  assign st.last_edge   = ({1'b0, e_idx_r} == edge_total_r - 1'b1);
  assign st.last_pass   = ({1'b0, pass_r} == pass_limit - 1'b1);
  assign st.dst_reached = reached_r[dst_r];
  assign st.walk_done   = (cur_r == src_r) || (len_r == LEN_W'(MAX_NODES - 1));
  assign st.out_last    = out_last_r;

  // ---- control-side registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCNT_W'(MAX_NODES);
      edge_total_r <= '0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_node_count;
      end
      if (cmd.clear_store) begin
        edge_total_r <= '0;
      end else if (cmd.append && (edge_total_r != ECNT_W'(MAX_EDGES))) begin
        edge_total_r <= edge_total_r + 1'b1;
      end
    end
  end

  // ---- solve working registers ----
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_r <= in_start_node;
      dst_r <= in_dest_node;
    end
    if (cmd.init) begin
      // only the start node is reached
      reached_r <= {{(MAX_NODES-1){1'b0}}, 1'b1} << src_r;
      e_idx_r   <= '0;
      pass_r    <= '0;
    end else if (cmd.relax) begin
      if (better) begin
        reached_r[edge_q.to] <= 1'b1;
      end
      if (st.last_edge) begin
        e_idx_r <= '0;
        pass_r  <= pass_r + 1'b1;
      end else begin
        e_idx_r <= e_idx_r + 1'b1;
      end
    end
    if (cmd.walk_start) begin
      cur_r <= dst_r;
      len_r <= '0;
    end else if (cmd.walk_wr) begin
      len_r <= len_r + 1'b1;
      cur_r <= pred_q;
      if (st.walk_done) begin
        idx_r <= len_r[NODE_W-1:0];
      end
    end else if (cmd.emit_next) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (cmd.load_trivial) begin
      out_node_r  <= in_start_node;
      out_dist_r  <= '0;
      out_reach_r <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (cmd.load_unreach) begin
      out_node_r  <= dst_r;
      out_dist_r  <= '0;
      out_reach_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (cmd.emit_ld) begin
      out_node_r  <= stack_q.node;
      out_dist_r  <= stack_q.total;
      out_reach_r <= 1'b1;
      out_last_r  <= (idx_r == '0);
    end
  end

  assign out_path_node     = out_node_r;
  assign out_path_distance = out_dist_r;
  assign out_reachable     = out_reach_r;
  assign out_last          = out_last_r;

endmodule
